[rtl/bcc_pkg.sv]
`timescale 1ns / 1ps

package bcc_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned StampW = 32;
	localparam int unsigned CountW = 8;

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CLICK_INTERVAL = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_MULTI_TARGET = 2'd3;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
	localparam logic [15:0] CLICK_INTERVAL_RESET = 16'd300;
	localparam logic [CountW-1:0] MULTI_TARGET_RESET = 8'd0;

	localparam logic [CountW-1:0] COUNT_MAX = 8'd255;
	localparam logic [CountW-1:0] COUNT_ONE = 8'd1;
	localparam logic [CountW-1:0] COUNT_TWO = 8'd2;

	typedef struct packed {
		logic [15:0]       debounce_ms;
		logic [15:0]       long_press_ms;
		logic [15:0]       click_interval_ms;
		logic [CountW-1:0] multi_click_target;
	} cfg_t;

	typedef struct packed {
		logic went_down;
		logic went_up;
		logic long_press;
		logic single_click;
		logic double_click;
		logic multi_click;
	} flags_t;

endpackage

[rtl/bcc_if.sv]
`timescale 1ns / 1ps

interface bcc_in_if;
	logic        valid;
	logic        ready;
	logic        pressed;
	logic [31:0] now_ms;

	modport source (output valid, output pressed, output now_ms, input ready);
	modport sink (input valid, input pressed, input now_ms, output ready);
endinterface

interface bcc_out_if;
	logic valid;
	logic ready;
	logic went_down;
	logic went_up;
	logic long_press;
	logic single_click;
	logic double_click;
	logic multi_click;

	modport source (
		output valid, output went_down, output went_up, output long_press,
		output single_click, output double_click, output multi_click, input ready
	);
	modport sink (
		input valid, input went_down, input went_up, input long_press,
		input single_click, input double_click, input multi_click, output ready
	);
endinterface

[rtl/bcc_core.sv]
`timescale 1ns / 1ps

module bcc_core import bcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              pressed,
	input  logic [StampW-1:0] now_ms,
	input  cfg_t              cfg,
	output flags_t            flags
);

	logic              level_q;
	logic [StampW-1:0] change_stamp_q;
	logic [StampW-1:0] press_stamp_q;
	logic [StampW-1:0] click_stamp_q;
	logic [CountW-1:0] click_total_q;

	logic              edge_ok;
	logic              press_edge;
	logic              release_edge;
	logic              is_long;
	logic              is_click;
	logic [StampW-1:0] since_change;
	logic [StampW-1:0] since_press;
	logic [StampW-1:0] since_click;
	logic [CountW-1:0] total_next;

	always_comb begin
		since_change = now_ms - change_stamp_q;
		since_press = now_ms - press_stamp_q;
		since_click = now_ms - click_stamp_q;
		edge_ok = (pressed != level_q) && (since_change >= {16'd0, cfg.debounce_ms});
		press_edge = edge_ok && pressed;
		release_edge = edge_ok && !pressed;
		is_long = release_edge && (since_press >= {16'd0, cfg.long_press_ms});
		is_click = release_edge && !is_long;
		if (since_click > {16'd0, cfg.click_interval_ms}) begin
			total_next = COUNT_ONE;
		end else if (click_total_q == COUNT_MAX) begin
			total_next = COUNT_MAX;
		end else begin
			total_next = click_total_q + COUNT_ONE;
		end
		flags.went_down = press_edge;
		flags.went_up = release_edge;
		flags.long_press = is_long;
		flags.single_click = is_click && (total_next == COUNT_ONE);
		flags.double_click = is_click && (total_next == COUNT_TWO);
		flags.multi_click = is_click && (cfg.multi_click_target != '0)
			&& (total_next == cfg.multi_click_target);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			change_stamp_q <= '0;
			press_stamp_q <= '0;
			click_stamp_q <= '0;
			click_total_q <= '0;
		end else if (step && edge_ok) begin
			level_q <= pressed;
			change_stamp_q <= now_ms;
			if (press_edge) begin
				press_stamp_q <= now_ms;
			end
			if (is_click) begin
				click_stamp_q <= now_ms;
				click_total_q <= total_next;
			end
		end
	end

endmodule

[rtl/button_click_classifier_unit.sv]
`timescale 1ns / 1ps
// An accepted sample word is registered in the input register, and its result word in the output register.
// Throughput is one word per cycle unless the result side stalls; the state update of one word completes
// in the same cycle that it leaves the input register.
// Reset clears the button state, the click run and both valid flags, and
// returns the four configuration registers to their default values.

module button_click_classifier_unit import bcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	bcc_in_if.sink              sample,
	bcc_out_if.source           result
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic              pressed_s1;
	logic [StampW-1:0] now_s1;
	logic              valid_s2;
	flags_t            flags_s2;
	flags_t            flags;
	logic              out_free;
	logic              advance;

	assign out_free = !valid_s2 || result.ready;
	assign advance = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.long_press_ms <= LONG_PRESS_RESET;
			cfg_q.click_interval_ms <= CLICK_INTERVAL_RESET;
			cfg_q.multi_click_target <= MULTI_TARGET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata;
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_wdata;
				REG_CLICK_INTERVAL: cfg_q.click_interval_ms <= cfg_wdata;
				REG_MULTI_TARGET: cfg_q.multi_click_target <= cfg_wdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			pressed_s1 <= sample.pressed;
			now_s1 <= sample.now_ms;
		end
		if (advance) begin
			flags_s2 <= flags;
		end
	end

	bcc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.pressed (pressed_s1),
		.now_ms  (now_s1),
		.cfg     (cfg_q),
		.flags   (flags)
	);

	assign result.valid = valid_s2;
	assign result.went_down = flags_s2.went_down;
	assign result.went_up = flags_s2.went_up;
	assign result.long_press = flags_s2.long_press;
	assign result.single_click = flags_s2.single_click;
	assign result.double_click = flags_s2.double_click;
	assign result.multi_click = flags_s2.multi_click;

endmodule

[rtl/bcc_checker.sv]
`timescale 1ns / 1ps

module bcc_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic went_down,
	input logic went_up,
	input logic long_press,
	input logic single_click,
	input logic double_click,
	input logic multi_click
);

	// A result word reports at most one accepted edge.
	a_one_edge: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(went_down && went_up))
		else $error("press and release reported in one word");

	// A long press is always the end of a release.
	a_long_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && long_press |-> went_up)
		else $error("long press without release");

	// Click flags come only from a short release.
	a_click_short: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (single_click || double_click || multi_click)
			|-> went_up && !long_press)
		else $error("click flag outside a short release");

	// The click count cannot be one and two at once.
	a_click_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(single_click && double_click))
		else $error("single and double click together");

	// A stalled result word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word withdrawn while stalled");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.went_down    (result.went_down),
	.went_up      (result.went_up),
	.long_press   (result.long_press),
	.single_click (result.single_click),
	.double_click (result.double_click),
	.multi_click  (result.multi_click)
);

[test/tb_button_click_classifier_unit.sv]
`timescale 1ns / 1ps

import bcc_pkg::*;

class click_scoreboard;
	logic [15:0] debounce_ms;
	logic [15:0] long_press_ms;
	logic [15:0] click_interval_ms;
	logic [7:0]  multi_target;

	logic        level_now;
	logic [31:0] change_stamp;
	logic [31:0] press_stamp;
	logic [31:0] click_stamp;
	logic [7:0]  click_total;

	flags_t      expected_q[$];
	int          errors;

	function new();
		debounce_ms = DEBOUNCE_RESET;
		long_press_ms = LONG_PRESS_RESET;
		click_interval_ms = CLICK_INTERVAL_RESET;
		multi_target = MULTI_TARGET_RESET;
		level_now = 1'b0;
		change_stamp = '0;
		press_stamp = '0;
		click_stamp = '0;
		click_total = '0;
		errors = 0;
	endfunction

	function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		case (idx)
			REG_DEBOUNCE: debounce_ms = val;
			REG_LONG_PRESS: long_press_ms = val;
			REG_CLICK_INTERVAL: click_interval_ms = val;
			REG_MULTI_TARGET: multi_target = val[CountW-1:0];
			default: ;
		endcase
	endfunction

	function flags_t classify(logic lvl, logic [31:0] now);
		flags_t      f;
		logic [31:0] dt;
		f = '0;
		if (lvl == level_now)
			return f;
		dt = now - change_stamp;
		if (dt < {16'd0, debounce_ms})
			return f;
		change_stamp = now;
		level_now = lvl;
		if (lvl) begin
			press_stamp = now;
			f.went_down = 1'b1;
			return f;
		end
		f.went_up = 1'b1;
		dt = now - press_stamp;
		if (dt >= {16'd0, long_press_ms}) begin
			f.long_press = 1'b1;
			return f;
		end
		dt = now - click_stamp;
		if (dt > {16'd0, click_interval_ms})
			click_total = COUNT_ONE;
		else if (click_total != COUNT_MAX)
			click_total = click_total + 8'd1;
		click_stamp = now;
		f.single_click = (click_total == COUNT_ONE);
		f.double_click = (click_total == COUNT_TWO);
		f.multi_click = (multi_target != 8'd0) && (click_total == multi_target);
		return f;
	endfunction

	function void note_sample(logic lvl, logic [31:0] now);
		expected_q.push_back(classify(lvl, now));
	endfunction

	task report(string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task check_result(flags_t got);
		flags_t want;
		string  field_names[6] = '{"went_down", "went_up", "long_press",
			"single_click", "double_click", "multi_click"};
		if (expected_q.size() == 0) begin
			report($sformatf("result word %b with nothing expected", got));
			return;
		end
		want = expected_q.pop_front();
		for (int i = 5; i >= 0; i--) begin
			if (got[i] !== want[i])
				report($sformatf("%s is %b, expected %b", field_names[5-i], got[i], want[i]));
		end
	endtask
endclass

module tb_button_click_classifier_unit;

	localparam int HOLD_CYCLES = 64;
	localparam int STALL_LIMIT = 3000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	bcc_in_if  sample_bus();
	bcc_out_if result_bus();

	click_scoreboard sb;
	logic [31:0]     clock_ms;
	int              n_sent;
	int              burst_left;
	bit              hold_req;
	int              quiet_cycles;

	button_click_classifier_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample(sample_bus),
		.result(result_bus)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_bus.valid && sample_bus.ready)
				sb.note_sample(sample_bus.pressed, sample_bus.now_ms);
			if (result_bus.valid && result_bus.ready)
				sb.check_result({result_bus.went_down, result_bus.went_up,
					result_bus.long_press, result_bus.single_click,
					result_bus.double_click, result_bus.multi_click});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int span;
		int phase_tick;
		result_bus.ready = 1'b0;
		phase_tick = 0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				@(negedge clk);
				phase_tick++;
				if (hold_req) begin
					hold_req = 1'b0;
					result_bus.ready = 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
				end else begin
					case (mode)
						0: result_bus.ready = 1'b1;
						1: result_bus.ready = 1'($urandom_range(0, 1));
						2: result_bus.ready = ($urandom_range(0, 4) != 0);
						default: result_bus.ready = (phase_tick % 4 != 0);
					endcase
				end
			end
		end
	end

	task send_word(logic lvl, logic [31:0] now);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				sample_bus.valid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		sample_bus.valid = 1'b1;
		sample_bus.pressed = lvl;
		sample_bus.now_ms = now;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		n_sent++;
	endtask

	task settle();
		@(negedge clk);
		sample_bus.valid = 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] span_near(logic [31:0] base);
		case ($urandom_range(0, 5))
			0: return (base == 0) ? 32'd0 : base - 32'd1;
			1: return base;
			2: return base + 32'd1;
			3: return $urandom_range(0, base);
			4: return base + $urandom_range(1, 400);
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	task chatter(logic lvl);
		repeat ($urandom_range(0, 2)) begin
			clock_ms += $urandom_range(0, 3);
			send_word(!lvl, clock_ms);
			clock_ms += $urandom_range(0, 3);
			send_word(lvl, clock_ms);
		end
	endtask

	task gesture();
		clock_ms += span_near({16'd0, sb.debounce_ms});
		send_word(1'b1, clock_ms);
		chatter(1'b1);
		repeat ($urandom_range(0, 2)) begin
			clock_ms += $urandom_range(0, 50);
			send_word(1'b1, clock_ms);
		end
		if ($urandom_range(0, 3) == 0)
			clock_ms += span_near({16'd0, sb.long_press_ms});
		else
			clock_ms += span_near({16'd0, sb.debounce_ms});
		send_word(1'b0, clock_ms);
		chatter(1'b0);
		if ($urandom_range(0, 2) == 0)
			clock_ms += span_near({16'd0, sb.click_interval_ms});
		else
			clock_ms += $urandom_range(0, 60);
	endtask

	task noise_word();
		if ($urandom_range(0, 3) == 0)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(0, 10);
		send_word(1'($urandom_range(0, 1)), clock_ms);
	endtask

	task run_phase(logic [15:0] deb, logic [15:0] lp, logic [15:0] iv, logic [15:0] tgt,
			int count, bit rapid);
		int first;
		int hold_at;
		bit held;
		settle();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_CLICK_INTERVAL, iv);
		write_reg(REG_MULTI_TARGET, tgt);
		first = n_sent;
		hold_at = $urandom_range(4, count / 2);
		held = 1'b0;
		while (n_sent - first < count) begin
			if (!held && n_sent - first >= hold_at) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (rapid) begin
				clock_ms += 32'd1;
				send_word(1'b1, clock_ms);
				clock_ms += 32'd1;
				send_word(1'b0, clock_ms);
			end else if ($urandom_range(0, 9) == 0) begin
				noise_word();
			end else begin
				gesture();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_wdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.pressed = 1'b0;
		sample_bus.now_ms = '0;
		hold_req = 1'b0;
		burst_left = 0;
		n_sent = 0;
		quiet_cycles = 0;
		clock_ms = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default settings: debounce edges, a click run, a long press and a wrapped stamp.
		send_word(1'b0, 32'd0);
		send_word(1'b1, 32'd5);
		send_word(1'b1, 32'd20);
		send_word(1'b0, 32'd30);
		send_word(1'b0, 32'd40);
		send_word(1'b1, 32'd60);
		send_word(1'b0, 32'd80);
		send_word(1'b1, 32'd100);
		send_word(1'b0, 32'd120);
		send_word(1'b1, 32'd200);
		send_word(1'b0, 32'd1300);
		send_word(1'b1, 32'd1320);
		send_word(1'b0, 32'd1340);
		send_word(1'b1, 32'hFFFF_FFF0);
		send_word(1'b0, 32'h0000_0010);
		settle();
		// Only the low byte of the target register is kept.
		write_reg(REG_MULTI_TARGET, 16'hFF01);
		send_word(1'b1, 32'd64);
		send_word(1'b0, 32'd96);
		send_word(1'b1, 32'd1024);
		send_word(1'b0, 32'd1056);
		settle();
		write_reg(REG_MULTI_TARGET, 16'd2);
		send_word(1'b1, 32'd1088);
		send_word(1'b0, 32'd1120);
		send_word(1'b1, 32'd2048);
		send_word(1'b0, 32'd3048);
		send_word(1'b1, 32'd3067);
		send_word(1'b1, 32'd3068);

		clock_ms = 32'd4000;
		run_phase(16'd20, 16'd1000, 16'd300, 16'd3, 250, 1'b0);
		run_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'h5AFF, 560, 1'b1);
		run_phase(16'hFFFF, 16'd0, 16'd0, 16'd1, 200, 1'b0);
		run_phase(16'd5, 16'd50, 16'd100, 16'd2, 250, 1'b0);
		clock_ms = 32'hFFFF_F000;
		run_phase(16'd1, 16'hFFFF, 16'd0, 16'h0100, 200, 1'b0);
		repeat (2) begin
			run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 500)),
				16'($urandom_range(0, 400)), 16'($urandom_range(0, 6)), 150, 1'b0);
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
